// File: sv/assert_macros.svh
// assertion macros shared by the modular exponentiation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mexp_pkg.sv
// package with constants, types and state encodings for modular exponentiation
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int EXP_BITS   = 63;
  localparam int BASE_W     = 32;
  localparam int EXP_W      = 63;
  localparam int RES_W      = 30;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 32;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int X_W        = 2 * RES_W;
  localparam int Q_W        = RES_W + 1;
  localparam int CNT_W      = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  localparam logic [RES_W-1:0] MODULUS    = 30'd1000000007;
  localparam logic [MUL_W-1:0] MODULUS_X2 = 32'd2000000014;
  localparam logic [Q_W-1:0]   BARRETT_MU = 31'd1152921496;
  localparam logic [RES_W-1:0] RES_ONE    = 30'd1;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] op_a;
    logic [RES_W-1:0] op_b;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_HOLD
  } top_state_t;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_PROD,
    MM_QUOT,
    MM_QP,
    MM_SUB,
    MM_FIX
  } mm_state_t;

endpackage

// File: sv/modular_exponentiation.sv
// modular exponentiation top level: base^exponent mod 1000000007, square and multiply
// each modular multiply runs on the one shared multiplier and barrett reducer
// one word in flight; the next input word can be taken in the cycle after the result is loaded
// synchronous active-low reset clears the sequencer and the output valid
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_exponentiation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mexp_pkg::IN_DATA_W-1:0]      in_tdata,   // base, exponent, pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mexp_pkg::OUT_DATA_W-1:0]     out_tdata   // power_mod, pad
);
  import mexp_pkg::*;

  top_state_t        state_r, state_nxt;
  logic [RES_W-1:0]  acc_r, acc_nxt;
  logic [RES_W-1:0]  base_r, base_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [RES_W-1:0]  out_data_r, out_data_nxt;

  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  logic [BASE_W-1:0] in_base;
  logic [EXP_W-1:0]  in_exp;

  assign in_base = in_tdata[BASE_W-1:0];
  assign in_exp  = in_tdata[BASE_W+EXP_W-1:BASE_W];

  mexp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mm_req.start   = 1'b0;
    mm_req.op_a    = {{(MUL_W-RES_W){1'b0}}, mm_rsp.res};
    mm_req.op_b    = mm_rsp.res;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mm_req.start = 1'b1;
          mm_req.op_a  = in_base;
          mm_req.op_b  = RES_ONE;
          exp_nxt      = in_exp[EXP_BITS-1:0];
          cnt_nxt      = CNT_W'(EXP_BITS - 1);
          acc_nxt      = RES_ONE;
          state_nxt    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_rsp.done) begin
          base_nxt     = mm_rsp.res;
          mm_req.start = 1'b1;
          mm_req.op_a  = {{(MUL_W-RES_W){1'b0}}, acc_r};
          mm_req.op_b  = acc_r;
          state_nxt    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          if (exp_r[EXP_BITS-1]) begin
            mm_req.start = 1'b1;
            mm_req.op_b  = base_r;
            state_nxt    = ST_MULT;
          end else if (cnt_r == '0) begin
            state_nxt = ST_HOLD;
          end else begin
            mm_req.start = 1'b1;
            cnt_nxt      = cnt_r - 1'b1;
            exp_nxt      = exp_r << 1;
            state_nxt    = ST_SQUARE;
          end
        end
      end
      ST_MULT: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          if (cnt_r == '0) begin
            state_nxt = ST_HOLD;
          end else begin
            mm_req.start = 1'b1;
            cnt_nxt      = cnt_r - 1'b1;
            exp_nxt      = exp_r << 1;
            state_nxt    = ST_SQUARE;
          end
        end
      end
      ST_HOLD: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = acc_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_data_r};

  `ASSERT_IMPLY(a_done_busy, mm_rsp.done,
    state_r == ST_REDUCE || state_r == ST_SQUARE || state_r == ST_MULT,
    "multiplier result with no operation pending")
  `ASSERT_IMPLY(a_hold_last, state_r == ST_HOLD, cnt_r == '0, "result before last exponent bit")
  `ASSERT_ALWAYS(a_out_range, !out_tvalid_r || out_data_r < MODULUS, "result word not reduced")

endmodule

// File: sv/mexp_modmul.sv
// modular multiplier on one shared 32x32 multiplier with barrett reduction
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  mm_state_t        state_r, state_nxt;
  logic [MUL_W-1:0] a_r, a_nxt;
  logic [RES_W-1:0] b_r, b_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [MUL_W-1:0] qp_r, qp_nxt;
  logic [MUL_W-1:0] rem_r, rem_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic             done_r, done_nxt;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [MUL_W-1:0]  rem_m1;
  logic [MUL_W-1:0]  rem_m2;

  assign mul_p  = mul_a * mul_b;
  assign rem_m1 = rem_r - {{(MUL_W-RES_W){1'b0}}, MODULUS};
  assign rem_m2 = rem_r - MODULUS_X2;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    x_nxt     = x_r;
    q_nxt     = q_r;
    qp_nxt    = qp_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      MM_IDLE: begin
        if (req.start) begin
          a_nxt     = req.op_a;
          b_nxt     = req.op_b;
          state_nxt = MM_PROD;
        end
      end
      MM_PROD: begin
        mul_a     = a_r;
        mul_b     = {{(MUL_W-RES_W){1'b0}}, b_r};
        x_nxt     = mul_p[X_W-1:0];
        state_nxt = MM_QUOT;
      end
      MM_QUOT: begin
        mul_a     = {{(MUL_W-Q_W){1'b0}}, x_r[X_W-1:RES_W-1]};
        mul_b     = {{(MUL_W-Q_W){1'b0}}, BARRETT_MU};
        q_nxt     = mul_p[RES_W+Q_W:RES_W+1];
        state_nxt = MM_QP;
      end
      MM_QP: begin
        mul_a     = {{(MUL_W-Q_W){1'b0}}, q_r};
        mul_b     = {{(MUL_W-RES_W){1'b0}}, MODULUS};
        qp_nxt    = mul_p[MUL_W-1:0];
        state_nxt = MM_SUB;
      end
      MM_SUB: begin
        rem_nxt   = x_r[MUL_W-1:0] - qp_r;
        state_nxt = MM_FIX;
      end
      MM_FIX: begin
        priority if (rem_r >= MODULUS_X2) begin
          res_nxt = rem_m2[RES_W-1:0];
        end else if (rem_r >= {{(MUL_W-RES_W){1'b0}}, MODULUS}) begin
          res_nxt = rem_m1[RES_W-1:0];
        end else begin
          res_nxt = rem_r[RES_W-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = MM_IDLE;
      end
      default: begin
        state_nxt = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    qp_r  <= qp_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  `ASSERT_IMPLY(a_start_idle, req.start, state_r == MM_IDLE, "modmul started while busy")
  `ASSERT_IMPLY(a_done_idle, done_r, state_r == MM_IDLE, "modmul done outside idle")
  `ASSERT_IMPLY(a_res_range, done_r, res_r < MODULUS, "modmul result not reduced")

endmodule
